// ===== src/rwq_pkg.sv =====
// Shared types, codes and helpers of the retransmit window queue.
`timescale 1ns / 1ps

package rwq_pkg;

    // Field widths of the input and result words
    localparam int ACTION_W   = 2;
    localparam int SEQ_W      = 8;
    localparam int HANDLE_W   = 16;
    localparam int START_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int RESUME_W   = 5;
    localparam int OCC_W      = 6;

    // Number of codes the start index field can carry
    localparam int START_CODES = 2 ** START_W;

    // Parameter defaults for the top level
    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int HANDLE_BITS_DEF  = 16;

    // Wraparound threshold of the acknowledgement rule
    localparam logic [SEQ_W-1:0] ACK_DISTANCE = SEQ_W'(100);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ACK  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FIND = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SEQ_W-1:0]    seq_number;
        logic [HANDLE_W-1:0] packet_handle;
        logic                start_from_head;
        logic [START_W-1:0]  start_index;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [HANDLE_W-1:0] handle_out;
        logic [RESUME_W-1:0] resume_index;
        logic                ack_covers;
        logic                window_empty;
        logic [OCC_W-1:0]    occupancy;
    } t_out_word;

    // Wrap-aware test of whether ack number a covers head number h
    function automatic logic f_ack_covers(input logic [SEQ_W-1:0] a,
                                          input logic [SEQ_W-1:0] h);
        logic covers;
        if (a < h && (h - a) > ACK_DISTANCE) begin
            covers = 1'b1;
        end else if (h < a && (a - h) > ACK_DISTANCE) begin
            covers = 1'b0;
        end else begin
            covers = (a >= h);
        end
        return covers;
    endfunction

endpackage

// ===== src/rwq_ram.sv =====
// Single-port-write, single-port-read slot memory with registered read data.
`timescale 1ns / 1ps

module rwq_ram import rwq_pkg::*; #(
    parameter int DEPTH = WINDOW_DEPTH_DEF,
    parameter int WIDTH = SEQ_W + HANDLE_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one slot
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one slot, hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rwq_ctrl.sv =====
// Window sequencer: pointers, valid bits and the reads and writes of the slot memory.
`timescale 1ns / 1ps

module rwq_ctrl import rwq_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int HANDLE_BITS  = HANDLE_BITS_DEF,
    localparam int IW = $clog2(WINDOW_DEPTH),
    localparam int CW = $clog2(WINDOW_DEPTH + 1),
    localparam int SB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W,
    localparam int WW = SEQ_W + SB
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in_word      i_in_word,
    output logic          o_res_valid,
    output t_out_word     o_res_word,
    input  logic          i_res_take,
    output logic          o_ram_we,
    output logic [IW-1:0] o_ram_waddr,
    output logic [WW-1:0] o_ram_wdata,
    output logic          o_ram_re,
    output logic [IW-1:0] o_ram_raddr,
    input  logic [WW-1:0] i_ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_head, r_tail, r_idx;
    logic [CW-1:0]         r_count, n_count;
    logic [WINDOW_DEPTH-1:0] r_valid;
    logic [ACTION_W-1:0]   r_act;
    logic [SEQ_W-1:0]      r_seq;
    logic [SB-1:0]         r_handle;
    logic                  r_first;

    logic                  in_accept;
    logic [IW-1:0]         start_idx, first_addr, next_idx;
    logic [IW-1:0]         mod_tab [START_CODES];
    logic [SEQ_W-1:0]      rd_seq;
    logic [SB-1:0]         rd_handle;
    logic                  slot_ok, match, head_wrap, find_done, done;
    logic                  is_full, no_entries, commit, find_step;
    logic                  push_ok, pop_ok;
    logic [IW+RESUME_W-1:0] resume_ext;
    logic [CW+OCC_W-1:0]   occ_ext;
    t_out_word             res;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] i);
        return (i == IW'(WINDOW_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // Fold the start index into the window range
    for (genvar g = 0; g < START_CODES; g++) begin : g_mod
        assign mod_tab[g] = IW'(g % WINDOW_DEPTH);
    end

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign start_idx  = i_in_word.start_from_head ? r_head : mod_tab[i_in_word.start_index];
    assign first_addr = (i_in_word.action == ACT_FIND) ? start_idx : r_head;
    assign next_idx   = f_next(r_idx);

    // Evaluate the slot word last read from the memory
    assign rd_seq     = i_ram_rdata[WW-1 -: SEQ_W];
    assign rd_handle  = i_ram_rdata[SB-1:0];
    assign slot_ok    = r_valid[r_idx];
    assign match      = slot_ok && (rd_seq == r_seq);
    assign head_wrap  = !r_first && (r_idx == r_head);
    assign find_done  = !slot_ok || match || head_wrap;
    assign done       = (r_act != ACT_FIND) || find_done;
    assign is_full    = (r_count == CW'(WINDOW_DEPTH));
    assign no_entries = (r_count == '0);
    assign push_ok    = (r_act == ACT_PUSH) && !is_full;
    assign pop_ok     = (r_act == ACT_POP) && !no_entries;

    assign o_res_valid = (r_state == S_EVAL) && done;
    assign commit      = o_res_valid && i_res_take;
    assign find_step   = (r_state == S_EVAL) && (r_act == ACT_FIND) && !find_done;

    // Build the result word
    always_comb begin
        res        = '0;
        n_count    = r_count;
        resume_ext = (IW + RESUME_W)'(next_idx);
        unique case (r_act)
            ACT_PUSH: begin
                if (is_full) begin
                    res.status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            ACT_POP: begin
                if (no_entries) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.found      = 1'b1;
                    res.handle_out = HANDLE_W'(rd_handle);
                    n_count        = r_count - 1'b1;
                end
            end
            ACT_ACK: begin
                if (!no_entries) begin
                    res.found      = 1'b1;
                    res.handle_out = HANDLE_W'(rd_handle);
                    res.ack_covers = f_ack_covers(r_seq, rd_seq);
                end
            end
            ACT_FIND: begin
                if (match) begin
                    res.found        = 1'b1;
                    res.handle_out   = HANDLE_W'(rd_handle);
                    res.resume_index = resume_ext[RESUME_W-1:0];
                end
            end
            default: begin
                res = '0;
            end
        endcase
        occ_ext          = (CW + OCC_W)'(n_count);
        res.window_empty = (n_count == '0);
        res.occupancy    = occ_ext[OCC_W-1:0];
    end

    assign o_res_word = res;

    // Memory ports: write on a committed push that is not full, read on accept and on each find step
    assign o_ram_we    = commit && push_ok;
    assign o_ram_waddr = r_tail;
    assign o_ram_wdata = {r_seq, r_handle};
    assign o_ram_re    = in_accept || find_step;
    assign o_ram_raddr = in_accept ? first_addr : next_idx;

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state, update pointers, count and valid bits on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count <= n_count;
                if (push_ok) begin
                    r_valid[r_tail] <= 1'b1;
                    r_tail          <= f_next(r_tail);
                end
                if (pop_ok) begin
                    r_valid[r_head] <= 1'b0;
                    r_head          <= f_next(r_head);
                end
            end
        end
    end

    // Capture the item and walk the find index
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_act    <= i_in_word.action;
            r_seq    <= i_in_word.seq_number;
            r_handle <= i_in_word.packet_handle[SB-1:0];
            r_idx    <= first_addr;
            r_first  <= 1'b1;
        end else if (find_step) begin
            r_idx   <= next_idx;
            r_first <= 1'b0;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WINDOW_DEPTH))
        else $error("entry count beyond window depth");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("valid bits disagree with entry count");

    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(WINDOW_DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail differ on empty or full window");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        find_step |=> $stable(r_head) && $stable(r_count))
        else $error("window changed during a find walk");

endmodule

// ===== src/retransmit_window_queue_core.sv =====
// Retransmit send window: top level with slot memory, sequencer and result register.
//
// Usage:
//   Input words (push, pop, ack check, find) arrive on i_in_valid / o_in_stall /
//   i_in_word; each produces exactly one result word on o_out_valid /
//   i_out_stall / o_out_word. A word moves when valid is high and stall low.
//   One word is worked on at a time: the sequencer reads the slot memory,
//   whose read data is registered, and evaluates the data in the next cycle.
//   Push, pop and ack check finish on that single read.
//   Find reads one slot per cycle from its start slot until it meets a match,
//   an empty slot or the head again; the single memory read port sets that rate.
//   The result register lets the next word be accepted while a result waits;
//   if the receiver stalls, the finished word is held in the sequencer and no
//   pointer or memory update takes effect until it can be handed over.
//   Synchronous active-low reset empties the window at once: pointers, count
//   and valid bits clear; slot memory contents are not cleared.
`timescale 1ns / 1ps

module retransmit_window_queue_core import rwq_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int HANDLE_BITS  = HANDLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int SB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int WW = SEQ_W + SB;

    logic          res_valid, res_take;
    t_out_word     res_word;
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;
    logic          r_out_valid;
    t_out_word     r_out_word;

    rwq_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .HANDLE_BITS  (HANDLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_res_valid (res_valid),
        .o_res_word  (res_word),
        .i_res_take  (res_take),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    rwq_ram #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (WW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Take a new result when the register is empty or being drained
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== test/retransmit_window_queue_core_test.sv =====
// Self-checking testbench for the retransmit window queue core: directed words, then random.
`timescale 1ns / 1ps

module retransmit_window_queue_core_test;
    import rwq_pkg::*;

    localparam int WIN           = WINDOW_DEPTH_DEF;
    localparam int RANDOM_WORDS  = 1100;
    localparam int IDLE_PCT      = 11;
    localparam int CALM_FIRST    = 400;
    localparam int CALM_LAST     = 650;
    // longest find plus handover, with margin
    localparam int SETTLE_CYCLES = 60;
    localparam int LIMIT_NS      = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word want;
    } t_dir_row;

    localparam t_out_word UNTYPED = '0;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Shadow copy of the send window
    logic [SEQ_W-1:0]    win_seq    [WIN] = '{default: '0};
    logic [HANDLE_W-1:0] win_handle [WIN] = '{default: '0};
    bit                  win_live   [WIN] = '{default: 1'b0};
    int unsigned         win_head   = 0;
    int unsigned         win_tail   = 0;
    int unsigned         win_count  = 0;

    t_out_word pending_results[$];

    int unsigned fault_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned words_sent    = 0;
    int unsigned full_rejects  = 0;
    int unsigned empty_rejects = 0;
    int unsigned full_reached  = 0;
    int unsigned find_hits     = 0;
    int unsigned find_misses   = 0;
    int unsigned acks_covered  = 0;

    bit                  calm        = 1'b0;
    bit                  filling     = 1'b1;
    logic [SEQ_W-1:0]    next_seq    = '0;
    logic [RESUME_W-1:0] last_resume = '0;

    retransmit_window_queue_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_in_word make_word(input logic [ACTION_W-1:0] action,
                                           input logic [SEQ_W-1:0] seq,
                                           input logic [HANDLE_W-1:0] handle,
                                           input logic from_head,
                                           input logic [START_W-1:0] start);
        t_in_word w;
        w.action          = action;
        w.seq_number      = seq;
        w.packet_handle   = handle;
        w.start_from_head = from_head;
        w.start_index     = start;
        return w;
    endfunction

    function automatic t_out_word make_result(input logic [STATUS_W-1:0] status,
                                              input logic found,
                                              input logic [HANDLE_W-1:0] handle,
                                              input logic [RESUME_W-1:0] resume,
                                              input logic covers,
                                              input logic empty,
                                              input logic [OCC_W-1:0] occ);
        t_out_word r;
        r.status       = status;
        r.found        = found;
        r.handle_out   = handle;
        r.resume_index = resume;
        r.ack_covers   = covers;
        r.window_empty = empty;
        r.occupancy    = occ;
        return r;
    endfunction

    // Wraparound coverage test: a far-behind ack counts as wrapped ahead
    function automatic logic ack_reaches(input int a, input int h);
        if (a < h && (h - a) > int'(ACK_DISTANCE)) begin
            return 1'b1;
        end
        if (h < a && (a - h) > int'(ACK_DISTANCE)) begin
            return 1'b0;
        end
        return a >= h;
    endfunction

    // Apply one word to the shadow window and return the result it must produce
    function automatic t_out_word window_step(input t_in_word w);
        t_out_word   r;
        int unsigned idx;
        bit          walk_first;
        bit          walk_halt;
        r = '0;
        case (w.action)
            ACT_PUSH: begin
                if (win_count >= WIN) begin
                    r.status = ST_FULL;
                end else begin
                    win_seq[win_tail]    = w.seq_number;
                    win_handle[win_tail] = w.packet_handle;
                    win_live[win_tail]   = 1'b1;
                    win_tail             = (win_tail + 1) % WIN;
                    win_count++;
                end
            end
            ACT_POP: begin
                if (win_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.found            = 1'b1;
                    r.handle_out       = win_handle[win_head];
                    win_live[win_head] = 1'b0;
                    win_head           = (win_head + 1) % WIN;
                    win_count--;
                end
            end
            ACT_ACK: begin
                if (win_count != 0) begin
                    r.found      = 1'b1;
                    r.handle_out = win_handle[win_head];
                    r.ack_covers = ack_reaches(int'(w.seq_number), int'(win_seq[win_head]));
                end
            end
            ACT_FIND: begin
                // walk to first match; stop at an empty slot or back at the head
                idx        = w.start_from_head ? win_head : int'(w.start_index) % WIN;
                walk_first = 1'b1;
                walk_halt  = 1'b0;
                for (int g = 0; g <= WIN + 1; g++) begin
                    if (!win_live[idx] || win_seq[idx] == w.seq_number) begin
                        break;
                    end
                    if (!walk_first && idx == win_head) begin
                        walk_halt = 1'b1;
                        break;
                    end
                    walk_first = 1'b0;
                    idx        = (idx + 1) % WIN;
                end
                if (!walk_halt && win_live[idx] && win_seq[idx] == w.seq_number) begin
                    r.found        = 1'b1;
                    r.handle_out   = win_handle[idx];
                    r.resume_index = RESUME_W'((idx + 1) % WIN);
                end
            end
        endcase
        r.window_empty = (win_count == 0);
        r.occupancy    = OCC_W'(win_count);
        return r;
    endfunction

    // Draw a random word, mostly well-formed traffic around the live window
    function automatic t_in_word pick_word();
        t_in_word    w;
        int          roll;
        int unsigned off;
        int          ack_steps [9] = '{-101, -100, -99, -1, 0, 1, 99, 100, 101};
        w.seq_number      = SEQ_W'($urandom);
        w.packet_handle   = HANDLE_W'($urandom);
        w.start_from_head = 1'($urandom);
        w.start_index     = START_W'($urandom);
        // swing between filling and draining so occupancy sweeps end to end
        if (win_count == WIN && $urandom_range(3) == 0) begin
            filling = 1'b0;
        end else if (win_count == 0 && $urandom_range(3) == 0) begin
            filling = 1'b1;
        end else if ($urandom_range(63) == 0) begin
            filling = !filling;
        end
        roll = $urandom_range(99);
        if (roll < 55) begin
            w.action = filling ? ACT_PUSH : ACT_POP;
        end else if (roll < 70) begin
            w.action = filling ? ACT_POP : ACT_PUSH;
        end else if (roll < 82) begin
            w.action = ACT_ACK;
        end else begin
            w.action = ACT_FIND;
        end
        case (w.action)
            ACT_PUSH: begin
                if ($urandom_range(3) != 0) begin
                    w.seq_number = next_seq;
                    next_seq++;
                end else if ($urandom_range(1) == 1) begin
                    // repeat a recent number so finds see duplicates
                    w.seq_number = next_seq - SEQ_W'($urandom_range(1, 4));
                end
            end
            ACT_ACK: begin
                if (win_count != 0 && $urandom_range(2) != 0) begin
                    w.seq_number = SEQ_W'(int'(win_seq[win_head]) + ack_steps[$urandom_range(8)]);
                end
            end
            ACT_FIND: begin
                if (win_count != 0 && $urandom_range(4) < 3) begin
                    off          = $urandom_range(win_count - 1);
                    w.seq_number = win_seq[(win_head + off) % WIN];
                end
                if (!w.start_from_head && $urandom_range(1) == 1) begin
                    w.start_index = last_resume;
                end
            end
            default: begin
            end
        endcase
        return w;
    endfunction

    // Offer one word, hold it until taken, then log what it must return
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_want);
        t_out_word want;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        want = window_step(w);
        if (typed) begin
            want = typed_want;
        end
        pending_results.push_back(want);
        words_sent++;
        if (want.status == ST_FULL) begin
            full_rejects++;
        end
        if (want.status == ST_EMPTY) begin
            empty_rejects++;
        end
        if (w.action == ACT_PUSH && want.status == ST_OK && want.occupancy == WIN) begin
            full_reached++;
        end
        if (w.action == ACT_ACK && want.ack_covers) begin
            acks_covered++;
        end
        if (w.action == ACT_FIND) begin
            if (want.found) begin
                find_hits++;
                last_resume = want.resume_index;
            end else begin
                find_misses++;
            end
        end
        @(negedge clk);
    endtask

    // Stall the result side at random, except in the calm stretch
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Check each handed-over result against the oldest expectation
    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS) begin
                    $display("[%0t] Unexpected result word %p", $realtime, out_word);
                end
            end else begin
                want = pending_results.pop_front();
                if (out_word.status !== want.status || out_word.found !== want.found ||
                    out_word.handle_out !== want.handle_out ||
                    out_word.resume_index !== want.resume_index ||
                    out_word.ack_covers !== want.ack_covers ||
                    out_word.window_empty !== want.window_empty ||
                    out_word.occupancy !== want.occupancy) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("[%0t] Result %0d mismatch", $realtime, results_seen);
                        $display("  expected st=%0d fd=%b h=%h ri=%0d ac=%b em=%b oc=%0d",
                                 want.status, want.found, want.handle_out, want.resume_index,
                                 want.ack_covers, want.window_empty, want.occupancy);
                        $display("  actual   st=%0d fd=%b h=%h ri=%0d ac=%b em=%b oc=%0d",
                                 out_word.status, out_word.found, out_word.handle_out,
                                 out_word.resume_index, out_word.ack_covers,
                                 out_word.window_empty, out_word.occupancy);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row dir_rows[$];

        // Empty window: rejected pop, idle ack and find
        dir_rows.push_back('{make_word(ACT_POP, 8'd0, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_EMPTY, 1'b0, 16'h0000, 5'd0, 1'b0, 1'b1, 6'd0)});
        dir_rows.push_back('{make_word(ACT_ACK, 8'd0, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b0, 16'h0000, 5'd0, 1'b0, 1'b1, 6'd0)});
        dir_rows.push_back('{make_word(ACT_FIND, 8'd0, 16'h0000, 1'b1, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b0, 16'h0000, 5'd0, 1'b0, 1'b1, 6'd0)});
        // Fill three slots with extreme and mid values
        dir_rows.push_back('{make_word(ACT_PUSH, 8'd0, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b0, 16'h0000, 5'd0, 1'b0, 1'b0, 6'd1)});
        dir_rows.push_back('{make_word(ACT_PUSH, 8'd255, 16'hFFFF, 1'b1, 5'd31), 1'b1,
                             make_result(ST_OK, 1'b0, 16'h0000, 5'd0, 1'b0, 1'b0, 6'd2)});
        dir_rows.push_back('{make_word(ACT_PUSH, 8'd150, 16'h1234, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b0, 16'h0000, 5'd0, 1'b0, 1'b0, 6'd3)});
        dir_rows.push_back('{make_word(ACT_ACK, 8'd0, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'h0000, 5'd0, 1'b1, 1'b0, 6'd3)});
        // Finds from the head, from a slot index, and from an empty slot
        dir_rows.push_back('{make_word(ACT_FIND, 8'd255, 16'h0000, 1'b1, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'hFFFF, 5'd2, 1'b0, 1'b0, 6'd3)});
        dir_rows.push_back('{make_word(ACT_FIND, 8'd150, 16'h0000, 1'b0, 5'd2), 1'b1,
                             make_result(ST_OK, 1'b1, 16'h1234, 5'd3, 1'b0, 1'b0, 6'd3)});
        dir_rows.push_back('{make_word(ACT_FIND, 8'd77, 16'h0000, 1'b0, 5'd31), 1'b1,
                             make_result(ST_OK, 1'b0, 16'h0000, 5'd0, 1'b0, 1'b0, 6'd3)});
        dir_rows.push_back('{make_word(ACT_POP, 8'd0, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'h0000, 5'd0, 1'b0, 1'b0, 6'd2)});
        // Ack wraparound edges around head number 255
        dir_rows.push_back('{make_word(ACT_ACK, 8'd154, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'hFFFF, 5'd0, 1'b1, 1'b0, 6'd2)});
        dir_rows.push_back('{make_word(ACT_ACK, 8'd155, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'hFFFF, 5'd0, 1'b0, 1'b0, 6'd2)});
        dir_rows.push_back('{make_word(ACT_POP, 8'd0, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'hFFFF, 5'd0, 1'b0, 1'b0, 6'd1)});
        // Ack edges around head number 150
        dir_rows.push_back('{make_word(ACT_ACK, 8'd250, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'h1234, 5'd0, 1'b1, 1'b0, 6'd1)});
        dir_rows.push_back('{make_word(ACT_ACK, 8'd251, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'h1234, 5'd0, 1'b0, 1'b0, 6'd1)});
        dir_rows.push_back('{make_word(ACT_ACK, 8'd149, 16'h0000, 1'b0, 5'd0), 1'b1,
                             make_result(ST_OK, 1'b1, 16'h1234, 5'd0, 1'b0, 1'b0, 6'd1)});
        // Duplicate numbers: chain finds through the resume index
        dir_rows.push_back('{make_word(ACT_PUSH, 8'd150, 16'hA5A5, 1'b1, 5'd21), 1'b0, UNTYPED});
        dir_rows.push_back('{make_word(ACT_PUSH, 8'd7, 16'h5A5A, 1'b0, 5'd10), 1'b0, UNTYPED});
        dir_rows.push_back('{make_word(ACT_FIND, 8'd150, 16'hFFFF, 1'b1, 5'd31), 1'b0, UNTYPED});
        dir_rows.push_back('{make_word(ACT_FIND, 8'd150, 16'h0000, 1'b0, 5'd3), 1'b0, UNTYPED});
        dir_rows.push_back('{make_word(ACT_FIND, 8'd150, 16'h0000, 1'b0, 5'd4), 1'b0, UNTYPED});
        dir_rows.push_back('{make_word(ACT_FIND, 8'd7, 16'h0000, 1'b0, 5'd0), 1'b0, UNTYPED});
        // Unused fields all ones must be ignored
        dir_rows.push_back('{make_word(ACT_ACK, 8'hAA, 16'hFFFF, 1'b1, 5'd31), 1'b0, UNTYPED});

        // Hold reset, release it on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            send_word(pick_word(), 1'b0, UNTYPED);
        end
        calm     = 1'b0;
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d words, %0d results; window filled %0d times, %0d full / %0d empty rejects",
                 words_sent, results_seen, full_reached, full_rejects, empty_rejects);
        $display("Finds matched %0d, missed %0d; acks covering head %0d",
                 find_hits, find_misses, acks_covered);
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d result failures", fault_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(LIMIT_NS);
        $display("Time limit hit with %0d results outstanding", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
